// File: hdl/tgi_pkg.sv
// ----------------------------------------------------------------------------
// tgi_pkg
// Shared constants and types for the trilinear grid interpolator.
// ----------------------------------------------------------------------------
package tgi_pkg;

    localparam int GRID_MAX     = 64;
    localparam int IDX_BITS     = $clog2(GRID_MAX);
    localparam int ADDR_BITS    = 3 * IDX_BITS;
    localparam int GRID_CELLS   = GRID_MAX * GRID_MAX * GRID_MAX;
    localparam int COORD_BITS   = 7;
    localparam int FRAC_BITS    = 16;
    localparam int VALUE_BITS   = 32;
    localparam int POINT_BITS   = 23;
    localparam int CORNERS      = 8;
    localparam int CNT_BITS     = $clog2(CORNERS);
    localparam int QCNT_BITS    = CNT_BITS + 1;
    localparam int LERP_OPS     = CORNERS - 1;
    localparam int PROD_BITS    = VALUE_BITS + FRAC_BITS + 2;
    localparam int SUM_BITS     = VALUE_BITS + 2;

    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;

    localparam logic [COORD_BITS-1:0] GRID_MAX_C   = COORD_BITS'(GRID_MAX);
    localparam logic [COORD_BITS-1:0] GRID_SIZE_RST = COORD_BITS'(GRID_MAX);

    // register indexes
    localparam logic REG_GRID_SIZE = 1'b0;

    // item function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // fraction select codes
    localparam logic [1:0] FRAC_X = 2'd0;
    localparam logic [1:0] FRAC_Y = 2'd1;
    localparam logic [1:0] FRAC_Z = 2'd2;

    // lerp op boundaries: four x steps, two y steps, one z step
    localparam logic [CNT_BITS-1:0] OP_FIRST_Y = CNT_BITS'(4);
    localparam logic [CNT_BITS-1:0] OP_FIRST_Z = CNT_BITS'(6);
    localparam logic [CNT_BITS-1:0] OP_LAST    = CNT_BITS'(LERP_OPS - 1);
    localparam logic [CNT_BITS-1:0] CORNER_LAST = CNT_BITS'(CORNERS - 1);

    typedef struct packed {
        logic                capture;
        logic                mem_write;
        logic                rd_issue;
        logic [CNT_BITS-1:0] corner;
        logic                lerp_mul;
        logic                lerp_add;
        logic [1:0]          frac_sel;
        logic                load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_query;
        logic write_ok;
        logic oor;
    } dp_status_t;

endpackage

// File: hdl/trilinear_grid_interpolator.sv
// ----------------------------------------------------------------------------
// trilinear_grid_interpolator
// Trilinear interpolation over a 64^3 grid of signed Q16.16 samples.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A write item is accepted and decoded and
// gives no transfer on the output; a query outside the grid is also loaded
// out. An in-range query is accepted and decoded, makes 8 corner reads
// through the single-ported grid memory and a drain step, then seven linear
// steps, each a multiply and an add on one shared multiplier, and the output
// load. The result sits in an output register, so the next item is accepted
// while it waits. Grid entries must be written before a query reads them.
module trilinear_grid_interpolator (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [tgi_pkg::APB_ADDR_BITS-1:0]      paddr,
    input  logic [tgi_pkg::APB_DATA_BITS-1:0]      pwdata,
    output logic [tgi_pkg::APB_DATA_BITS-1:0]      prdata,
    output logic                                   pready,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   func,
    input  logic [tgi_pkg::COORD_BITS-1:0]         grid_x,
    input  logic [tgi_pkg::COORD_BITS-1:0]         grid_y,
    input  logic [tgi_pkg::COORD_BITS-1:0]         grid_z,
    input  logic signed [tgi_pkg::VALUE_BITS-1:0]  write_value,
    input  logic [tgi_pkg::POINT_BITS-1:0]         point_x,
    input  logic [tgi_pkg::POINT_BITS-1:0]         point_y,
    input  logic [tgi_pkg::POINT_BITS-1:0]         point_z,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [tgi_pkg::VALUE_BITS-1:0]  interp_value,
    output logic                                   out_of_range
);
    import tgi_pkg::*;

    ctrl_cmd_t             cmd;
    dp_status_t            status;
    logic [COORD_BITS-1:0] grid_size_reg;
    logic                  reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_ADDR_BITS-1] == REG_GRID_SIZE);
    assign prdata  = reg_hit ? {{(APB_DATA_BITS-COORD_BITS){1'b0}}, grid_size_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= GRID_SIZE_RST;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            grid_size_reg <= pwdata[COORD_BITS-1:0];
        end
    end

    tgi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tgi_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .grid_size    (grid_size_reg),
        .func         (func),
        .grid_x       (grid_x),
        .grid_y       (grid_y),
        .grid_z       (grid_z),
        .write_value  (write_value),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .interp_value (interp_value),
        .out_of_range (out_of_range)
    );

endmodule

// File: hdl/tgi_ctrl.sv
// ----------------------------------------------------------------------------
// tgi_ctrl
// Sequencer: accepts items, steps corner reads and lerp ops, loads output.
// ----------------------------------------------------------------------------
module tgi_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    input  tgi_pkg::dp_status_t   status,
    output tgi_pkg::ctrl_cmd_t    cmd
);
    import tgi_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_MUL    = 3'd4;
    localparam logic [2:0] S_ADD    = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.corner = cnt_reg;
        if (cnt_reg < OP_FIRST_Y)
        begin
            cmd.frac_sel = FRAC_X;
        end
        else if (cnt_reg < OP_FIRST_Z)
        begin
            cmd.frac_sel = FRAC_Y;
        end
        else
        begin
            cmd.frac_sel = FRAC_Z;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!status.is_query)
                begin
                    cmd.mem_write = status.write_ok;
                    state_next    = S_IDLE;
                end
                else if (status.oor)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_issue = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CORNER_LAST)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                cnt_next   = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.lerp_mul = 1'b1;
                state_next   = S_ADD;
            end
            S_ADD:
            begin
                cmd.lerp_add = 1'b1;
                if (cnt_reg == OP_LAST)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = cmd.load_out || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: hdl/tgi_datapath.sv
// ----------------------------------------------------------------------------
// tgi_datapath
// Grid memory, corner addressing, operand queue and shared lerp unit.
// ----------------------------------------------------------------------------
module tgi_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tgi_pkg::ctrl_cmd_t                   cmd,
    output tgi_pkg::dp_status_t                  status,
    input  logic [tgi_pkg::COORD_BITS-1:0]       grid_size,
    input  logic                                 func,
    input  logic [tgi_pkg::COORD_BITS-1:0]       grid_x,
    input  logic [tgi_pkg::COORD_BITS-1:0]       grid_y,
    input  logic [tgi_pkg::COORD_BITS-1:0]       grid_z,
    input  logic signed [tgi_pkg::VALUE_BITS-1:0] write_value,
    input  logic [tgi_pkg::POINT_BITS-1:0]       point_x,
    input  logic [tgi_pkg::POINT_BITS-1:0]       point_y,
    input  logic [tgi_pkg::POINT_BITS-1:0]       point_z,
    output logic signed [tgi_pkg::VALUE_BITS-1:0] interp_value,
    output logic                                 out_of_range
);
    import tgi_pkg::*;

    localparam logic signed [SUM_BITS-1:0] VMAX =
        SUM_BITS'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_BITS-1:0] VMIN = -VMAX - SUM_BITS'(1);
    localparam logic signed [PROD_BITS-1:0] ROUND_HALF =
        PROD_BITS'(64'sd1 <<< (FRAC_BITS - 1));

    // item capture
    logic                  func_reg;
    logic                  write_ok_reg;
    logic                  oor_reg;
    logic [ADDR_BITS-1:0]  wr_addr_reg;
    logic [VALUE_BITS-1:0] wval_reg;
    logic [IDX_BITS-1:0]   lo_reg   [3];
    logic [IDX_BITS-1:0]   hi_reg   [3];
    logic [FRAC_BITS-1:0]  frac_reg [3];

    logic [COORD_BITS-1:0] size_eff;
    logic [POINT_BITS-1:0] pt     [3];
    logic [COORD_BITS-1:0] ipart  [3];
    logic [COORD_BITS-1:0] ilo_m1 [3];
    logic [IDX_BITS-1:0]   lo_c   [3];
    logic [IDX_BITS-1:0]   hi_c   [3];
    logic [POINT_BITS-1:0] upper;
    logic                  oor_c;
    logic                  write_ok_c;
    logic [COORD_BITS-1:0] gxm, gym, gzm;

    // memory
    logic [VALUE_BITS-1:0] mem [0:GRID_CELLS-1];
    logic [VALUE_BITS-1:0] mem_q_reg;
    logic [ADDR_BITS-1:0]  mem_addr;
    logic [IDX_BITS-1:0]   cx, cy, cz;
    logic                  push_reg;

    // operand queue and lerp unit
    logic [VALUE_BITS-1:0]        q_reg [CORNERS];
    logic [QCNT_BITS-1:0]         qcnt_reg;
    logic signed [PROD_BITS-1:0]  prod_reg;
    logic signed [VALUE_BITS-1:0] base_reg;
    logic signed [VALUE_BITS:0]   diff;
    logic signed [FRAC_BITS:0]    fsel;
    logic signed [PROD_BITS-1:0]  prod_c;
    logic signed [PROD_BITS-1:0]  rounded;
    logic signed [SUM_BITS-1:0]   step;
    logic signed [SUM_BITS-1:0]   res_wide;
    logic [VALUE_BITS-1:0]        res_sat;

    logic signed [VALUE_BITS-1:0] out_value_reg;
    logic                         out_oor_reg;

    assign status.is_query = (func_reg == FUNC_QUERY);
    assign status.write_ok = write_ok_reg;
    assign status.oor      = oor_reg;

    assign interp_value = out_value_reg;
    assign out_of_range = out_oor_reg;

    always_comb
    begin
        size_eff = (grid_size > GRID_MAX_C) ? GRID_MAX_C : grid_size;
        upper    = {size_eff, {FRAC_BITS{1'b0}}};
        pt[0]    = point_x;
        pt[1]    = point_y;
        pt[2]    = point_z;
        oor_c    = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            ipart[k]  = pt[k][POINT_BITS-1:FRAC_BITS];
            ilo_m1[k] = ipart[k] - 1'b1;
            lo_c[k]   = ilo_m1[k][IDX_BITS-1:0];
            hi_c[k]   = (ipart[k] == size_eff) ? ilo_m1[k][IDX_BITS-1:0]
                                               : ipart[k][IDX_BITS-1:0];
            if (ipart[k] == '0 || pt[k] > upper)
            begin
                oor_c = 1'b1;
            end
        end
        write_ok_c = (grid_x != '0) && (grid_x <= GRID_MAX_C) &&
                     (grid_y != '0) && (grid_y <= GRID_MAX_C) &&
                     (grid_z != '0) && (grid_z <= GRID_MAX_C);
        gxm = grid_x - 1'b1;
        gym = grid_y - 1'b1;
        gzm = grid_z - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg     <= func;
            write_ok_reg <= write_ok_c;
            oor_reg      <= oor_c;
            wr_addr_reg  <= {gzm[IDX_BITS-1:0], gym[IDX_BITS-1:0], gxm[IDX_BITS-1:0]};
            wval_reg     <= write_value;
            for (int k = 0; k < 3; k++)
            begin
                lo_reg[k]   <= lo_c[k];
                hi_reg[k]   <= hi_c[k];
                frac_reg[k] <= pt[k][FRAC_BITS-1:0];
            end
        end
    end

    // corner k: bit 0 selects x, bit 1 y, bit 2 z
    assign cx       = cmd.corner[0] ? hi_reg[0] : lo_reg[0];
    assign cy       = cmd.corner[1] ? hi_reg[1] : lo_reg[1];
    assign cz       = cmd.corner[2] ? hi_reg[2] : lo_reg[2];
    assign mem_addr = cmd.rd_issue ? {cz, cy, cx} : wr_addr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mem_write)
        begin
            mem[mem_addr] <= wval_reg;
        end
        if (cmd.rd_issue)
        begin
            mem_q_reg <= mem[mem_addr];
        end
    end

    always_comb
    begin
        diff = $signed({q_reg[1][VALUE_BITS-1], q_reg[1]}) -
               $signed({q_reg[0][VALUE_BITS-1], q_reg[0]});
        case (cmd.frac_sel)
            FRAC_X:  fsel = $signed({1'b0, frac_reg[0]});
            FRAC_Y:  fsel = $signed({1'b0, frac_reg[1]});
            FRAC_Z:  fsel = $signed({1'b0, frac_reg[2]});
            default: fsel = '0;
        endcase
        prod_c   = diff * fsel;
        rounded  = (prod_reg + ROUND_HALF) >>> FRAC_BITS;
        step     = rounded[SUM_BITS-1:0];
        res_wide = SUM_BITS'(base_reg) + step;
        if (res_wide > VMAX)
        begin
            res_sat = VMAX[VALUE_BITS-1:0];
        end
        else if (res_wide < VMIN)
        begin
            res_sat = VMIN[VALUE_BITS-1:0];
        end
        else
        begin
            res_sat = res_wide[VALUE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push_reg <= 1'b0;
            qcnt_reg <= '0;
        end
        else
        begin
            push_reg <= cmd.rd_issue;
            if (cmd.capture)
            begin
                qcnt_reg <= '0;
            end
            else if (push_reg || cmd.lerp_add)
            begin
                qcnt_reg <= qcnt_reg + 1'b1;
            end
            else if (cmd.lerp_mul)
            begin
                qcnt_reg <= qcnt_reg - QCNT_BITS'(2);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_reg)
        begin
            q_reg[qcnt_reg[CNT_BITS-1:0]] <= mem_q_reg;
        end
        else if (cmd.lerp_add)
        begin
            q_reg[qcnt_reg[CNT_BITS-1:0]] <= res_sat;
        end
        else if (cmd.lerp_mul)
        begin
            for (int i = 0; i < CORNERS - 2; i++)
            begin
                q_reg[i] <= q_reg[i+2];
            end
        end
        if (cmd.lerp_mul)
        begin
            prod_reg <= prod_c;
            base_reg <= $signed(q_reg[0]);
        end
        if (cmd.load_out)
        begin
            out_value_reg <= oor_reg ? '0 : $signed(q_reg[0]);
            out_oor_reg   <= oor_reg;
        end
    end

endmodule

// File: hdl/tgi_checker.sv
// ----------------------------------------------------------------------------
// tgi_checker
// Port-level checks for the trilinear grid interpolator.
// ----------------------------------------------------------------------------
module tgi_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_stall,
    input logic                                  out_valid,
    input logic                                  out_stall,
    input logic signed [tgi_pkg::VALUE_BITS-1:0] interp_value,
    input logic                                  out_of_range
);
    import tgi_pkg::*;

    // one item at a time: an input transfer is followed by a stall
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted back to back");

    // out-of-range results carry a zero value
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_of_range) |-> (interp_value == '0))
        else $error("out-of-range result with nonzero value");

    // no result can follow a transfer that was just accepted
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !out_valid) |=> !out_valid)
        else $error("result appeared in the cycle after accept");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(interp_value) &&
                                      $stable(out_of_range)))
        else $error("stalled output transfer changed");

endmodule

bind trilinear_grid_interpolator tgi_checker u_tgi_checker (.*);
